// ===== src/oadf_pkg.sv =====
// Package for the obstacle-avoiding drive controller: codes, beat layouts,
// register indexes and reset values. No dependencies.
`timescale 1ns / 1ps

package oadf_pkg;

  // Register file
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CRUISE_SPEED = 3'd0,
    REG_SAFETY_DIST  = 3'd1,
    REG_TURN_TIME    = 3'd2,
    REG_REVERSE_TIME = 3'd3,
    REG_SPIN_TIME    = 3'd4
  } cfg_reg_e;

  localparam logic [7:0]  CruiseSpeedRst  = 8'd200;
  localparam logic [15:0] SafetyDistRst   = 16'd20;
  localparam logic [15:0] TurnTimeRst     = 16'd400;
  localparam logic [15:0] ReverseTimeRst  = 16'd500;
  localparam logic [15:0] SpinTimeRst     = 16'd700;

  // Remote command bytes (ASCII)
  localparam logic [7:0] CmdAuto    = 8'h41;  // 'A'
  localparam logic [7:0] CmdManual  = 8'h4D;  // 'M'
  localparam logic [7:0] CmdForward = 8'h46;  // 'F'
  localparam logic [7:0] CmdBack    = 8'h42;  // 'B'
  localparam logic [7:0] CmdLeft    = 8'h4C;  // 'L'
  localparam logic [7:0] CmdRight   = 8'h52;  // 'R'
  localparam logic [7:0] CmdStop    = 8'h53;  // 'S'

  // Sensor angle that counts as straight ahead
  localparam logic [7:0] CenterAngle = 8'd90;

  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_FWD   = 3'd1,
    ACT_BACK  = 3'd2,
    ACT_LEFT  = 3'd3,
    ACT_RIGHT = 3'd4,
    ACT_STOP  = 3'd5
  } motor_act_e;

  typedef enum logic [1:0] {
    PH_ADVANCE  = 2'd0,
    PH_EVALUATE = 2'd1,
    PH_TURN     = 2'd2,
    PH_REVERSE  = 2'd3
  } drive_phase_e;

  typedef enum logic [1:0] {
    MSG_NONE     = 2'd0,
    MSG_OBSTACLE = 2'd1,
    MSG_BLOCKED  = 2'd2
  } status_msg_e;

  // Input beat payload (tdata), lowest field in the lowest bits
  typedef struct packed {
    logic [31:0] now_ms;
    logic [15:0] best_distance;
    logic [7:0]  best_angle;
    logic [15:0] front_distance;
    logic [7:0]  command_code;
  } in_beat_t;

  localparam int unsigned InDataW = $bits(in_beat_t);

  // Output beat payload (tdata), padded to whole bytes
  typedef struct packed {
    logic [6:0]   pad;
    drive_phase_e drive_state;
    logic         autonomous_mode;
    status_msg_e  status_message;
    logic         aim_center;
    logic [7:0]   motor_speed;
    motor_act_e   motor_action;
  } out_beat_t;

  localparam int unsigned OutDataW = $bits(out_beat_t);

endpackage

// ===== src/obstacle_avoid_drive_fsm_top.sv =====
// Obstacle-avoiding drive controller top level: input register, one pass of
// decision logic, output register. Depends on oadf_pkg.
`timescale 1ns / 1ps

// How to use:
//  - Slave stream: one beat per control-loop pass. tuser carries has_command,
//    tdata carries the command byte, distances, best scan angle and time.
//  - Master stream: one result beat per input beat, in order: motor action,
//    speed, sensor aim, status message, mode and drive phase after the pass.
//  - Config: cfg_we_i/cfg_idx_i/cfg_data_i write one register per cycle;
//    indexes beyond the register list are dropped. Write only while idle.
//  - Path: a beat accepted lands in the input register, and its result is
//    registered into the output register (master side) once the output is free.
//  - Throughput: one beat per cycle while tready is high; the decision logic
//    (two 32-bit time subtractions and compares) sits between input and output registers.
//  - Stall: while the receiver holds tready low, the result waits in the
//    output register and one more beat is taken into the input register;
//    then s_axis_tready drops until the master side moves again.
//  - Reset: manual mode, advance phase, timers idle, registers at defaults,
//    both pipeline registers empty.

module obstacle_avoid_drive_fsm_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Slave stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [79:0] = command_code, front_distance, best_angle, best_distance, now_ms
  input  logic [oadf_pkg::InDataW-1:0]  s_axis_tdata,
  // [0] = has_command
  input  logic                          s_axis_tuser,
  // Master stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [16:0] = motor_action, motor_speed, aim_center, status_message,
  //          autonomous_mode, drive_state; zero padded to 24 bits
  output logic [oadf_pkg::OutDataW-1:0] m_axis_tdata,
  // Configuration write port
  input  logic                          cfg_we_i,
  input  logic [oadf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [oadf_pkg::CfgDataW-1:0] cfg_data_i
);
  import oadf_pkg::*;

  // Configuration registers
  logic [7:0]  cruise_speed_q;
  logic [15:0] safety_dist_q;
  logic [15:0] turn_time_q;
  logic [15:0] reverse_time_q;
  logic [15:0] spin_time_q;

  // Controller state
  logic         mode_auto_q,   mode_auto_d;
  drive_phase_e phase_q,       phase_d;
  logic         turn_started_q, turn_started_d;
  logic [31:0]  turn_start_q,  turn_start_d;
  logic         rev_started_q, rev_started_d;
  logic         spinning_q,    spinning_d;
  logic [31:0]  rev_start_q,   rev_start_d;

  // Pipeline registers
  logic      in_valid_q;
  in_beat_t  in_beat_q;
  logic      in_cmd_q;
  logic      out_valid_q;
  out_beat_t out_beat_q,  out_beat_d;

  logic        fire;
  logic        run;
  motor_act_e  act;
  status_msg_e msg;
  logic        aim;
  logic [31:0] turn_base;
  logic [31:0] rev_base;
  logic [31:0] turn_elapsed;
  logic [31:0] rev_elapsed;

  // Handshake: decide when the input register holds a beat and there is room
  assign fire          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_beat_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cruise_speed_q <= CruiseSpeedRst;
      safety_dist_q  <= SafetyDistRst;
      turn_time_q    <= TurnTimeRst;
      reverse_time_q <= ReverseTimeRst;
      spin_time_q    <= SpinTimeRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CRUISE_SPEED: cruise_speed_q <= cfg_data_i[7:0];
        REG_SAFETY_DIST:  safety_dist_q  <= cfg_data_i;
        REG_TURN_TIME:    turn_time_q    <= cfg_data_i;
        REG_REVERSE_TIME: reverse_time_q <= cfg_data_i;
        REG_SPIN_TIME:    spin_time_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Elapsed times; a timer that has not started yet starts at this pass
  assign turn_base    = turn_started_q ? turn_start_q : in_beat_q.now_ms;
  assign rev_base     = (!rev_started_q && !spinning_q) ? in_beat_q.now_ms : rev_start_q;
  assign turn_elapsed = in_beat_q.now_ms - turn_base;
  assign rev_elapsed  = in_beat_q.now_ms - rev_base;

  // One control-loop pass
  always_comb begin
    mode_auto_d    = mode_auto_q;
    phase_d        = phase_q;
    turn_started_d = turn_started_q;
    turn_start_d   = turn_start_q;
    rev_started_d  = rev_started_q;
    spinning_d     = spinning_q;
    rev_start_d    = rev_start_q;
    act            = ACT_NONE;
    msg            = MSG_NONE;
    aim            = 1'b0;
    run            = 1'b1;

    // Remote command
    if (in_cmd_q) begin
      if (in_beat_q.command_code == CmdAuto) begin
        mode_auto_d = 1'b1;
      end else if (in_beat_q.command_code == CmdManual) begin
        mode_auto_d = 1'b0;
        act         = ACT_STOP;
      end else if (!mode_auto_q) begin
        priority case (in_beat_q.command_code)
          CmdForward: act = ACT_FWD;
          CmdBack:    act = ACT_BACK;
          CmdLeft:    act = ACT_LEFT;
          CmdRight:   act = ACT_RIGHT;
          CmdStop:    act = ACT_STOP;
          default:    act = ACT_NONE;
        endcase
        run = 1'b0;
      end
    end
    if (!mode_auto_d) begin
      run = 1'b0;
    end

    // Autonomous machine
    if (run) begin
      unique case (phase_q)
        PH_ADVANCE: begin
          aim = 1'b1;
          if (in_beat_q.front_distance < safety_dist_q) begin
            act     = ACT_STOP;
            msg     = MSG_OBSTACLE;
            phase_d = PH_EVALUATE;
          end else begin
            act = ACT_FWD;
          end
        end
        PH_EVALUATE: begin
          if (in_beat_q.best_distance < safety_dist_q) begin
            msg     = MSG_BLOCKED;
            phase_d = PH_REVERSE;
          end else if (in_beat_q.best_angle < CenterAngle) begin
            act     = ACT_LEFT;
            phase_d = PH_TURN;
          end else if (in_beat_q.best_angle > CenterAngle) begin
            act     = ACT_RIGHT;
            phase_d = PH_TURN;
          end else begin
            phase_d = PH_ADVANCE;
          end
        end
        PH_TURN: begin
          turn_start_d   = turn_base;
          turn_started_d = 1'b1;
          if (turn_elapsed > {16'd0, turn_time_q}) begin
            act            = ACT_STOP;
            turn_started_d = 1'b0;
            phase_d        = PH_ADVANCE;
          end
        end
        PH_REVERSE: begin
          // Start backing up on the first pass of the phase
          if (!rev_started_q && !spinning_q) begin
            act           = ACT_BACK;
            rev_start_d   = in_beat_q.now_ms;
            rev_started_d = 1'b1;
          end
          if (!spinning_q && (rev_elapsed > {16'd0, reverse_time_q})) begin
            act         = ACT_RIGHT;
            rev_start_d = in_beat_q.now_ms;
            spinning_d  = 1'b1;
          end else if (spinning_q && (rev_elapsed > {16'd0, spin_time_q})) begin
            act           = ACT_STOP;
            rev_started_d = 1'b0;
            spinning_d    = 1'b0;
            phase_d       = PH_ADVANCE;
          end
        end
        default: ;
      endcase
    end

    // Result beat
    out_beat_d                 = '0;
    out_beat_d.motor_action    = act;
    out_beat_d.motor_speed     = ((act == ACT_FWD) || (act == ACT_BACK) ||
                                  (act == ACT_LEFT) || (act == ACT_RIGHT)) ?
                                 cruise_speed_q : 8'd0;
    out_beat_d.aim_center      = aim;
    out_beat_d.status_message  = msg;
    out_beat_d.autonomous_mode = mode_auto_d;
    out_beat_d.drive_state     = phase_d;
  end

  // Controller state and pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_auto_q    <= 1'b0;
      phase_q        <= PH_ADVANCE;
      turn_started_q <= 1'b0;
      turn_start_q   <= '0;
      rev_started_q  <= 1'b0;
      spinning_q     <= 1'b0;
      rev_start_q    <= '0;
      in_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (fire) begin
        mode_auto_q    <= mode_auto_d;
        phase_q        <= phase_d;
        turn_started_q <= turn_started_d;
        turn_start_q   <= turn_start_d;
        rev_started_q  <= rev_started_d;
        spinning_q     <= spinning_d;
        rev_start_q    <= rev_start_d;
        out_valid_q    <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_beat_q <= in_beat_t'(s_axis_tdata);
      in_cmd_q  <= s_axis_tuser;
    end
    if (fire) begin
      out_beat_q <= out_beat_d;
    end
  end

  // Checks on the controller
  a_spin_needs_reverse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    spinning_q |-> rev_started_q)
    else $error("spin phase active without a started back-up");

  a_aim_in_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_beat_q.aim_center) |->
      ((out_beat_q.drive_state == PH_ADVANCE && out_beat_q.motor_action == ACT_FWD) ||
       (out_beat_q.drive_state == PH_EVALUATE && out_beat_q.motor_action == ACT_STOP)))
    else $error("sensor aimed ahead outside the advance pass");

  a_blocked_reverses: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_beat_q.status_message == MSG_BLOCKED) |->
      (out_beat_q.drive_state == PH_REVERSE && out_beat_q.motor_action == ACT_NONE))
    else $error("blocked status without entering reverse");

  a_manual_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_beat_q.autonomous_mode) |->
      (!out_beat_q.aim_center && out_beat_q.status_message == MSG_NONE))
    else $error("autonomous outputs in manual mode");

  a_state_moves_on_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(phase_q) && $stable(mode_auto_q))
    else $error("controller state changed without a pass");

endmodule
